/* rtl/core/bght_pkg.sv */
// Boost group hold tracker package: transaction structs, group record, FSM states,
// mode and register codes, and constants for the margin arithmetic.
// No dependencies.
package bght_pkg;

    // Input transaction
    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         group;
        logic [63:0]        now;
        logic               restamp;
        logic [10:0]        util;
        logic signed [7:0]  new_boost;
    } bght_in_t;

    // Result transaction
    typedef struct packed {
        logic [10:0]        boosted_util;
        logic signed [11:0] margin;
        logic signed [7:0]  effective_boost;
        logic               boost_valid;
        logic signed [7:0]  group_boost;
        logic [15:0]        group_tasks;
    } bght_out_t;

    // One group's entry in the state RAM
    typedef struct packed {
        logic [15:0]        tasks;
        logic [63:0]        stamp;
        logic signed [7:0]  boost;
    } grp_rec_t;

    // Request into the margin unit
    typedef struct packed {
        logic               start;
        logic               enable;
        logic [10:0]        util;
        logic [10:0]        cap;
        logic signed [7:0]  boost;
    } mrg_req_t;

    // Response from the margin unit
    typedef struct packed {
        logic               done;
        logic signed [11:0] margin;
        logic [10:0]        boosted;
    } mrg_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_MUL,
        ST_MWAIT,
        ST_DONE
    } state_t;

    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_DEQ = 2'd1;
    localparam logic [1:0] MODE_QRY = 2'd2;
    localparam logic [1:0] MODE_SET = 2'd3;

    localparam logic REG_HOLD = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    localparam logic [31:0] HOLD_RESET = 32'd50000000;
    localparam logic [10:0] CAP_RESET  = 11'd1024;

    localparam logic signed [7:0] BOOST_CEIL  = 8'sd100;
    localparam logic signed [7:0] BOOST_FLOOR = -8'sd100;

    // x / 100 as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below about 1.8M
    localparam int PCT_DIV     = 100;
    localparam int RECIP_SHIFT = 26;
    localparam logic [19:0] RECIP_MUL = 20'((2 ** RECIP_SHIFT + PCT_DIV - 1) / PCT_DIV);

endpackage

/* rtl/core/bght_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bght_margin.sv */
// Margin unit: three-stage multiply, reciprocal divide by 100 and sign/add.
// Depends on bght_pkg.
module bght_margin (
    input  logic               clk,
    input  logic               rst_n,
    input  bght_pkg::mrg_req_t req,
    output bght_pkg::mrg_rsp_t rsp
);

    localparam logic [19:0] RECIP_MUL_W = bght_pkg::RECIP_MUL;

    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic        s1_neg_reg, s2_neg_reg;
    logic [10:0] s1_util_reg, s2_util_reg;
    logic [18:0] s1_prod_reg;
    logic [10:0] s2_quot_reg;
    logic signed [11:0] s3_margin_reg;
    logic [10:0] s3_boosted_reg;

    logic        use_margin;
    logic [10:0] opnd_a;
    logic [7:0]  opnd_b;
    logic [38:0] recip_prod;
    logic signed [11:0] margin_val;
    logic [11:0] sum_val;

    // Margin applies only with util within capacity
    assign use_margin = req.enable && (req.util <= req.cap);
    assign opnd_a     = req.boost[7] ? req.util : (req.cap - req.util);
    assign opnd_b     = req.boost[7] ? 8'(-req.boost) : req.boost;
    assign recip_prod = 39'(s1_prod_reg) * 39'(RECIP_MUL_W);
    assign margin_val = s2_neg_reg ? 12'(-{1'b0, s2_quot_reg}) : {1'b0, s2_quot_reg};
    assign sum_val    = {1'b0, s2_util_reg} + margin_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= req.start;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg    <= use_margin ? 19'(opnd_a) * 19'(opnd_b) : '0;
        s1_neg_reg     <= req.boost[7];
        s1_util_reg    <= req.util;
        s2_quot_reg    <= recip_prod[bght_pkg::RECIP_SHIFT +: 11];
        s2_neg_reg     <= s1_neg_reg;
        s2_util_reg    <= s1_util_reg;
        s3_margin_reg  <= margin_val;
        s3_boosted_reg <= sum_val[10:0];
    end

    assign rsp.done    = s3_vld_reg;
    assign rsp.margin  = s3_margin_reg;
    assign rsp.boosted = s3_boosted_reg;

endmodule

/* rtl/core/boost_group_hold_tracker.sv */
// Boost group hold tracker: per-group task count, stamp and boost kept in one RAM.
// ST_READ updates the entry; ST_SCAN rescans on a group's first task or when a query finds the
// held stamp expired; queries use the 3-stage margin unit; ST_DONE registers the result. Input
// stalls outside ST_IDLE; the scan walks the RAM one group per cycle over its single read port.
// Reset: group entries read as zero via per-entry valid flops, max/held cleared,
// hold_timeout = 50000000 and cpu_capacity = 1024. Depends on bght_pkg, bght_ram, bght_margin.
module boost_group_hold_tracker #(
    parameter int NUM_GROUPS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  bght_pkg::bght_in_t  in_data,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output bght_pkg::bght_out_t out_data,
    // configuration write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata
);

    localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CW = $clog2(NUM_GROUPS + 1);
    localparam int RW = $bits(bght_pkg::grp_rec_t);

    // Wrapping 64-bit age against the 32-bit hold time
    function automatic logic expired(input logic [63:0] now, input logic [63:0] stamp,
                                     input logic [31:0] timeout);
        logic [63:0] age;
        age = now - stamp;
        return age > {32'b0, timeout};
    endfunction

    // Control state
    bght_pkg::state_t        state_reg, state_next;
    logic [31:0]             hold_reg, hold_next;
    logic [10:0]             cap_reg, cap_next;
    logic [NUM_GROUPS-1:0]   entry_vld_reg, entry_vld_next;
    logic                    rd_vld_reg;
    logic signed [7:0]       max_boost_reg, max_boost_next;
    logic                    max_valid_reg, max_valid_next;
    logic [63:0]             held_stamp_reg, held_stamp_next;
    logic [CW-1:0]           scan_cnt_reg, scan_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload state
    bght_pkg::bght_in_t      item_reg, item_next;
    logic                    ok_reg, ok_next;
    logic                    found_reg, found_next;
    logic signed [7:0]       best_reg, best_next;
    logic [63:0]             best_stamp_reg, best_stamp_next;
    logic signed [7:0]       grp_boost_reg, grp_boost_next;
    logic [15:0]             grp_tasks_reg, grp_tasks_next;
    logic signed [11:0]      margin_reg, margin_next;
    logic [10:0]             boosted_reg, boosted_next;
    bght_pkg::bght_out_t     out_data_reg, out_data_next;

    // RAM port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [RW-1:0]           ram_rdata;
    bght_pkg::grp_rec_t      rd_rec, rec_mod;

    bght_pkg::mrg_req_t      mrg_req;
    bght_pkg::mrg_rsp_t      mrg_rsp;

    logic                    accept, in_ok, active, out_free;

    bght_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_GROUPS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (RW'(rec_mod)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bght_margin u_margin (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mrg_req),
        .rsp   (mrg_rsp)
    );

    assign in_stall  = (state_reg != bght_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_ok     = (32'(in_data.group) < NUM_GROUPS);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Never-written entries read as zero
    assign rd_rec = rd_vld_reg ? bght_pkg::grp_rec_t'(ram_rdata) : '0;

    // Scan: a group is live with tasks or while inside the hold window
    assign active = (rd_rec.tasks != '0) || !expired(item_reg.now, rd_rec.stamp, hold_reg);

    always_comb
    begin
        state_next      = state_reg;
        hold_next       = hold_reg;
        cap_next        = cap_reg;
        entry_vld_next  = entry_vld_reg;
        max_boost_next  = max_boost_reg;
        max_valid_next  = max_valid_reg;
        held_stamp_next = held_stamp_reg;
        scan_cnt_next   = scan_cnt_reg;
        out_valid_next  = out_valid_reg;
        item_next       = item_reg;
        ok_next         = ok_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_stamp_next = best_stamp_reg;
        grp_boost_next  = grp_boost_reg;
        grp_tasks_next  = grp_tasks_reg;
        margin_next     = margin_reg;
        boosted_next    = boosted_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(item_reg.group);
        ram_raddr       = '0;
        rec_mod         = rd_rec;
        mrg_req.start   = 1'b0;
        mrg_req.enable  = max_valid_reg && (max_boost_reg != '0);
        mrg_req.util    = item_reg.util;
        mrg_req.cap     = cap_reg;
        mrg_req.boost   = max_boost_reg;

        // configuration writes, taken in any state
        if (cfg_we)
        begin
            case (cfg_index)
                bght_pkg::REG_HOLD: hold_next = cfg_wdata;
                bght_pkg::REG_CAP:  cap_next  = cfg_wdata[10:0];
                default: ;
            endcase
        end

        // result register drains independently of the FSM
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bght_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next    = in_data;
                    ok_next      = in_ok;
                    margin_next  = '0;
                    boosted_next = '0;
                    ram_raddr    = in_ok ? AW'(in_data.group) : '0;
                    state_next   = bght_pkg::ST_READ;
                end
            end

            bght_pkg::ST_READ:
            begin
                case (item_reg.mode)
                    bght_pkg::MODE_ENQ:
                    begin
                        if (rd_rec.tasks != '1)
                        begin
                            rec_mod.tasks = rd_rec.tasks + 16'd1;
                        end
                        if (item_reg.restamp)
                        begin
                            rec_mod.stamp = item_reg.now;
                        end
                    end
                    bght_pkg::MODE_DEQ:
                    begin
                        if (rd_rec.tasks != '0)
                        begin
                            rec_mod.tasks = rd_rec.tasks - 16'd1;
                        end
                    end
                    bght_pkg::MODE_SET:
                    begin
                        if (item_reg.new_boost > bght_pkg::BOOST_CEIL)
                        begin
                            rec_mod.boost = bght_pkg::BOOST_CEIL;
                        end
                        else if (item_reg.new_boost < bght_pkg::BOOST_FLOOR)
                        begin
                            rec_mod.boost = bght_pkg::BOOST_FLOOR;
                        end
                        else
                        begin
                            rec_mod.boost = item_reg.new_boost;
                        end
                    end
                    default: ;
                endcase

                ram_we = ok_reg && (item_reg.mode != bght_pkg::MODE_QRY);
                if (ram_we)
                begin
                    entry_vld_next[ram_waddr] = 1'b1;
                end
                grp_boost_next = ok_reg ? rec_mod.boost : '0;
                grp_tasks_next = ok_reg ? rec_mod.tasks : '0;

                found_next    = 1'b0;
                best_next     = '0;
                scan_cnt_next = '0;
                if (item_reg.mode == bght_pkg::MODE_ENQ && ok_reg && rec_mod.tasks == 16'd1)
                begin
                    state_next = bght_pkg::ST_SCAN;
                end
                else if (item_reg.mode == bght_pkg::MODE_QRY)
                begin
                    if (expired(item_reg.now, held_stamp_reg, hold_reg))
                    begin
                        state_next = bght_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = bght_pkg::ST_MUL;
                    end
                end
                else
                begin
                    state_next = bght_pkg::ST_DONE;
                end
            end

            bght_pkg::ST_SCAN:
            begin
                // issue read of group scan_cnt; data of the group before arrives now
                ram_raddr     = scan_cnt_reg[AW-1:0];
                scan_cnt_next = scan_cnt_reg + CW'(1);
                if (scan_cnt_reg != '0)
                begin
                    // later groups win ties
                    if (active && (!found_reg || rd_rec.boost >= best_reg))
                    begin
                        found_next      = 1'b1;
                        best_next       = rd_rec.boost;
                        best_stamp_next = rd_rec.stamp;
                    end
                end
                if (scan_cnt_reg == CW'(NUM_GROUPS))
                begin
                    max_valid_next = found_next;
                    max_boost_next = found_next ? best_next : '0;
                    if (found_next)
                    begin
                        held_stamp_next = best_stamp_next;
                    end
                    state_next = (item_reg.mode == bght_pkg::MODE_QRY) ? bght_pkg::ST_MUL
                                                                       : bght_pkg::ST_DONE;
                end
            end

            bght_pkg::ST_MUL:
            begin
                mrg_req.start = 1'b1;
                state_next    = bght_pkg::ST_MWAIT;
            end

            bght_pkg::ST_MWAIT:
            begin
                if (mrg_rsp.done)
                begin
                    margin_next  = mrg_rsp.margin;
                    boosted_next = mrg_rsp.boosted;
                    state_next   = bght_pkg::ST_DONE;
                end
            end

            bght_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.boosted_util    = boosted_reg;
                    out_data_next.margin          = margin_reg;
                    out_data_next.effective_boost = max_valid_reg ? max_boost_reg : '0;
                    out_data_next.boost_valid     = max_valid_reg;
                    out_data_next.group_boost     = grp_boost_reg;
                    out_data_next.group_tasks     = grp_tasks_reg;
                    state_next                    = bght_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bght_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bght_pkg::ST_IDLE;
            hold_reg       <= bght_pkg::HOLD_RESET;
            cap_reg        <= bght_pkg::CAP_RESET;
            entry_vld_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            max_boost_reg  <= '0;
            max_valid_reg  <= 1'b0;
            held_stamp_reg <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_reg       <= hold_next;
            cap_reg        <= cap_next;
            entry_vld_reg  <= entry_vld_next;
            rd_vld_reg     <= entry_vld_reg[ram_raddr];
            max_boost_reg  <= max_boost_next;
            max_valid_reg  <= max_valid_next;
            held_stamp_reg <= held_stamp_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        ok_reg         <= ok_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        grp_boost_reg  <= grp_boost_next;
        grp_tasks_reg  <= grp_tasks_next;
        margin_reg     <= margin_next;
        boosted_reg    <= boosted_next;
        out_data_reg   <= out_data_next;
    end

endmodule

/* tb/tb_boost_group_hold_tracker.sv */
// Testbench for boost_group_hold_tracker: directed and random transactions through the
// valid/stall channels, with expected reports from an in-bench model of the group state.
// Depends on bght_pkg and the boost_group_hold_tracker RTL.
module tb_boost_group_hold_tracker;

    localparam int NUM_GROUPS     = 8;
    localparam int SETTLE         = 20;
    localparam int LONG_HOLD      = 400;   // receiver hold-off that backs the block up
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all

    // Scoreboard: tracks group state as each request is accepted and queues the
    // report that request must produce; reports are matched in order.
    class boost_scoreboard;
        logic [31:0]         hold_timeout;
        logic [10:0]         cpu_cap;
        logic [15:0]         tasks  [NUM_GROUPS];
        logic [63:0]         stamps [NUM_GROUPS];
        logic signed [7:0]   boosts [NUM_GROUPS];
        logic signed [7:0]   top_boost;
        logic                top_valid;
        logic [63:0]         held_stamp;
        bght_pkg::bght_out_t owed_reports [$];
        int                  errors;
        int                  n_results;

        function new();
            hold_timeout = bght_pkg::HOLD_RESET;
            cpu_cap      = bght_pkg::CAP_RESET;
            foreach (tasks[g])
            begin
                tasks[g]  = '0;
                stamps[g] = '0;
                boosts[g] = '0;
            end
            top_boost  = '0;
            top_valid  = 1'b0;
            held_stamp = '0;
            errors     = 0;
            n_results  = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == bght_pkg::REG_HOLD)
                hold_timeout = value;
            else
                cpu_cap = value[10:0];
        endfunction

        // wrapping distance past the hold window
        function bit is_stale(logic [63:0] now, logic [63:0] stamp);
            return (now - stamp) > {32'd0, hold_timeout};
        endfunction

        // max boost over active groups, later groups win ties
        function void rescan_groups(logic [63:0] now);
            bit                found;
            logic signed [7:0] best;
            logic [63:0]       best_stamp;
            int                g;
            found      = 1'b0;
            best       = '0;
            best_stamp = '0;
            for (g = 0; g < NUM_GROUPS; g++)
            begin
                if (tasks[g] == 0 && is_stale(now, stamps[g]))
                    continue;
                if (found && best > boosts[g])
                    continue;
                found      = 1'b1;
                best       = boosts[g];
                best_stamp = stamps[g];
            end
            top_valid = found;
            top_boost = found ? best : 8'sd0;
            if (found)
                held_stamp = best_stamp;
        endfunction

        function void note_request(bght_pkg::bght_in_t t);
            bght_pkg::bght_out_t rpt;
            int                  g;
            int                  m;
            int                  nb;
            g   = int'(t.group);
            rpt = '0;
            case (t.mode)
                bght_pkg::MODE_ENQ:
                begin
                    if (tasks[g] != 16'hFFFF)
                        tasks[g]++;
                    if (t.restamp)
                        stamps[g] = t.now;
                    if (tasks[g] == 1)
                        rescan_groups(t.now);
                end
                bght_pkg::MODE_DEQ:
                begin
                    if (tasks[g] != 0)
                        tasks[g]--;
                end
                bght_pkg::MODE_QRY:
                begin
                    if (is_stale(t.now, held_stamp))
                        rescan_groups(t.now);
                    m = 0;
                    if (top_valid && top_boost != 0 && t.util <= cpu_cap)
                    begin
                        if (top_boost > 0)
                            m = (int'(cpu_cap) - int'(t.util)) * int'(top_boost)
                                / bght_pkg::PCT_DIV;
                        else
                            m = -((int'(t.util) * -int'(top_boost)) / bght_pkg::PCT_DIV);
                    end
                    rpt.margin       = 12'(m);
                    rpt.boosted_util = 11'(int'(t.util) + m);
                end
                bght_pkg::MODE_SET:
                begin
                    nb = t.new_boost;
                    if (nb > bght_pkg::BOOST_CEIL)
                        nb = bght_pkg::BOOST_CEIL;
                    if (nb < bght_pkg::BOOST_FLOOR)
                        nb = bght_pkg::BOOST_FLOOR;
                    boosts[g] = nb[7:0];
                end
                default: ;
            endcase
            rpt.effective_boost = top_valid ? top_boost : 8'sd0;
            rpt.boost_valid     = top_valid;
            rpt.group_boost     = boosts[g];
            rpt.group_tasks     = tasks[g];
            owed_reports.push_back(rpt);
        endfunction

        function void flag(string field, longint want, longint got);
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_report(bght_pkg::bght_out_t got);
            bght_pkg::bght_out_t want;
            n_results++;
            if (owed_reports.size() == 0)
            begin
                errors++;
                $error("report with no transaction outstanding: %p", got);
                return;
            end
            want = owed_reports.pop_front();
            if (got.boosted_util !== want.boosted_util)
                flag("boosted_util", want.boosted_util, got.boosted_util);
            if (got.margin !== want.margin)
                flag("margin", want.margin, got.margin);
            if (got.effective_boost !== want.effective_boost)
                flag("effective_boost", want.effective_boost, got.effective_boost);
            if (got.boost_valid !== want.boost_valid)
                flag("boost_valid", want.boost_valid, got.boost_valid);
            if (got.group_boost !== want.group_boost)
                flag("group_boost", want.group_boost, got.group_boost);
            if (got.group_tasks !== want.group_tasks)
                flag("group_tasks", want.group_tasks, got.group_tasks);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bght_pkg::bght_in_t  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bght_pkg::bght_out_t out_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [31:0]         cfg_wdata = '0;

    boost_scoreboard sb = new();

    bit          gapless   = 1'b0;   // sender runs back to back
    bit          sink_free = 1'b0;   // receiver never stalls
    logic [63:0] sim_now   = '0;     // running timestamp for random traffic
    int          quiet_cycles = 0;

    boost_group_hold_tracker #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Monitor: both handshakes sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_report(out_data);
        end
    end

    // Watchdog: any handshake clears the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random runs of stall and pass, plus two long hold-offs that
    // fill the pipeline while the sender keeps offering.
    initial
    begin : result_sink
        int run_left;
        bit run_stall;
        int holds_done;
        int r;
        run_left   = 0;
        run_stall  = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < 2 && sb.n_results >= (holds_done == 0 ? 120 : 700))
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
                run_left = 0;
            end
            else
            begin
                if (run_left <= 0)
                begin
                    r = $urandom_range(0, 99);
                    if (sink_free)
                    begin
                        run_stall = 1'b0;
                        run_left  = 1;
                    end
                    else if (r < 45)
                    begin
                        run_stall = 1'b0;
                        run_left  = $urandom_range(1, 20);
                    end
                    else if (r < 50)
                    begin
                        run_stall = 1'b0;
                        run_left  = $urandom_range(50, 120);
                    end
                    else if (r < 88)
                    begin
                        run_stall = 1'b1;
                        run_left  = $urandom_range(1, 3);
                    end
                    else if (r < 97)
                    begin
                        run_stall = 1'b1;
                        run_left  = $urandom_range(4, 12);
                    end
                    else
                    begin
                        run_stall = 1'b1;
                        run_left  = $urandom_range(20, 60);
                    end
                end
                out_stall <= run_stall;
                run_left--;
            end
        end
    end

    function automatic bght_pkg::bght_in_t mk_txn(logic [1:0] mode, logic [2:0] grp,
                                                  logic [63:0] now, logic restamp,
                                                  logic [10:0] util,
                                                  logic signed [7:0] nb);
        bght_pkg::bght_in_t t;
        t.mode      = mode;
        t.group     = grp;
        t.now       = now;
        t.restamp   = restamp;
        t.util      = util;
        t.new_boost = nb;
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the next call can keep it asserted.
    task automatic send_txn(input bght_pkg::bght_in_t t);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (gapless || r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed report has come back.
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.owed_reports.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] hold, input logic [10:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= bght_pkg::REG_HOLD;
        cfg_wdata <= hold;
        @(negedge clk);
        cfg_index <= bght_pkg::REG_CAP;
        cfg_wdata <= {21'd0, cap};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(bght_pkg::REG_HOLD, hold);
        sb.write_reg(bght_pkg::REG_CAP, {21'd0, cap});
    endtask

    // Random traffic on a mostly monotonic timeline, stepped relative to the
    // hold window so groups move in and out of the held state.
    task automatic random_phase(input int count, input logic [63:0] start);
        bght_pkg::bght_in_t t;
        int                 i;
        int                 g;
        int                 r;
        int                 nb;
        int unsigned        span;
        logic [2:0]         busy [$];
        sim_now = start;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                gapless = ($urandom_range(0, 3) == 0);
            span = sb.hold_timeout / 3 + 8;
            r = $urandom_range(0, 99);
            if (r < 4)
                sim_now = {$urandom, $urandom};
            else if (r < 7)
                sim_now = sim_now - 64'($urandom_range(0, span));
            else
                sim_now = sim_now + 64'($urandom_range(0, span));

            t         = '0;
            t.now     = sim_now;
            t.group   = 3'($urandom_range(0, NUM_GROUPS - 1));
            t.restamp = ($urandom_range(0, 9) < 7);
            r = $urandom_range(0, 99);
            if (r < 30)
                t.mode = bght_pkg::MODE_ENQ;
            else if (r < 55)
                t.mode = bght_pkg::MODE_DEQ;
            else if (r < 85)
                t.mode = bght_pkg::MODE_QRY;
            else
                t.mode = bght_pkg::MODE_SET;

            // dequeues mostly hit groups that actually hold tasks
            if (t.mode == bght_pkg::MODE_DEQ && $urandom_range(0, 4) != 0)
            begin
                busy.delete();
                for (g = 0; g < NUM_GROUPS; g++)
                    if (sb.tasks[g] != 0)
                        busy.push_back(3'(g));
                if (busy.size() != 0)
                    t.group = busy[$urandom_range(0, busy.size() - 1)];
            end

            if ($urandom_range(0, 9) < 7)
                t.util = 11'($urandom_range(0, sb.cpu_cap));
            else
                t.util = 11'($urandom_range(0, 2047));
            if ($urandom_range(0, 99) < 85)
                nb = int'($urandom_range(0, 200)) - 100;
            else
                nb = int'($urandom_range(0, 255)) - 128;
            t.new_boost = 8'(nb);

            if ($urandom_range(0, 79) == 0)
                wait_drained(0);
            send_txn(t);
        end
        gapless = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] holds [7];
        logic [10:0] caps  [7];
        int          p;
        int          k;
        holds = '{32'd50000000, 32'd40, 32'd0, 32'hFFFF_FFFF, 32'd200, 32'd15, 32'd5000};
        caps  = '{11'd1024, 11'd1024, 11'd1, 11'd700, 11'd2047, 11'd0, 11'd512};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // --- directed, reset settings: hold 50M, capacity 1024 ---
        // nothing active yet, held stamp still fresh
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd0, 64'd0, 1'b0, 11'd2047, 8'sd0));
        // boost writes clamp to +/-100
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd0, 64'd0, 1'b0, 11'd0, 8'sd127));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd1, 64'd0, 1'b0, 11'd0, -8'sd128));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd2, 64'd0, 1'b0, 11'd0, 8'sd100));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd7, 64'd0, 1'b0, 11'd0, 8'sd100));
        // first task rescans; all zero stamps still held, tie goes to group 7
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd0, 64'd1000, 1'b1, 11'd5, 8'sd0));
        // full margin, zero headroom, util above capacity
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd2, 64'd2000, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd7, 64'd2000, 1'b0, 11'd1024, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd0, 64'd2000, 1'b0, 11'd1025, 8'sd0));
        // held stamp expires: only the group with a task survives
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd0, 64'd60_000_000, 1'b0, 11'd2047, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd0, 64'd60_000_000, 1'b0, 11'd0, -8'sd50));
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd0, 64'd60_000_100, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd0, 64'd60_000_200, 1'b0, 11'd500, 8'sd0));
        // count drops to zero and stays there
        send_txn(mk_txn(bght_pkg::MODE_DEQ, 3'd0, 64'd60_000_200, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_DEQ, 3'd0, 64'd60_000_200, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_DEQ, 3'd0, 64'd60_000_200, 1'b0, 11'd0, 8'sd0));
        // rescan finds no active group
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd0, 64'd60_000_300, 1'b0, 11'd300, 8'sd0));
        // enqueue without restamp: winner's stamp is zero
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd1, 64'd120_000_000, 1'b0, 11'd0, 8'sd0));
        // negative boost margins
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd1, 64'd120_000_010, 1'b0, 11'd1000, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd1, 64'd120_000_010, 1'b0, 11'd0, -8'sd7));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd1, 64'd120_000_020, 1'b0, 11'd1024, 8'sd0));
        // timestamp wraps through zero
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd4, 64'hFFFF_FFFF_FFFF_FFFB, 1'b1, 11'd0,
                        8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_SET, 3'd4, 64'd0, 1'b0, 11'd0, 8'sd60));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd4, 64'd3, 1'b0, 11'd200, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_DEQ, 3'd4, 64'd3, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd4, 64'd4, 1'b1, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd4, 64'd10, 1'b0, 11'd100, 8'sd0));

        // --- random phases, one register setting each ---
        for (p = 0; p < 7; p++)
        begin
            wait_drained(SETTLE);
            apply_settings(holds[p], caps[p]);
            random_phase(150, (p == 6) ? 64'hFFFF_FFFF_FFFF_F000 : {$urandom, $urandom});
        end

        // --- short back-to-back burst on one group, receiver always ready ---
        sink_free = 1'b1;
        gapless   = 1'b1;
        for (k = 0; k < 8; k++)
            send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd5, sim_now, 1'b0, 11'(k), 8'(k)));
        send_txn(mk_txn(bght_pkg::MODE_DEQ, 3'd5, sim_now, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd5, sim_now, 1'b1, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_ENQ, 3'd5, sim_now, 1'b0, 11'd0, 8'sd0));
        send_txn(mk_txn(bght_pkg::MODE_QRY, 3'd5, sim_now + 64'd1, 1'b0, 11'd256, 8'sd0));
        gapless   = 1'b0;
        sink_free = 1'b0;

        wait_drained(SETTLE);
        if (sb.errors == 0 && sb.owed_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bght_pkg.sv
rtl/core/bght_ram.sv
rtl/core/bght_margin.sv
rtl/core/boost_group_hold_tracker.sv
tb/tb_boost_group_hold_tracker.sv
